// ===== rtl/base64_stream_decoder_assert.svh =====
// Assertion macros for the Base64 stream decoder checker.
// Depends on a clk and a rst signal in the scope where a macro is used.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define B64SD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("base64 decoder assertion failed");

// Next-cycle implication, disabled while reset is high.
`define B64SD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("base64 decoder assertion failed");

`endif

// ===== rtl/b64sd_pkg.sv =====
// Shared types, constants and the character classifier of the Base64 decoder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package b64sd_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int LIMIT_WIDTH = 16;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;
  localparam int QUEUE_DEPTH = 4;

  localparam int APB_ADDR_WIDTH = 3;
  localparam logic [APB_ADDR_WIDTH-1:0] ADDR_OUTPUT_LIMIT = 3'd0;

  // Classifier codes: skip, pad and bad lie above the 64 sextet values; plus and slash are sextets.
  localparam logic [6:0] SYM_SKIP = 7'd64;
  localparam logic [6:0] SYM_PAD  = 7'd65;
  localparam logic [6:0] SYM_BAD  = 7'd66;
  localparam logic [6:0] SYM_PLUS = 7'd62;
  localparam logic [6:0] SYM_SLASH = 7'd63;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_INVALID  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  // One queued command: up to three data bytes, then an optional status.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      ndata;
    logic            has_status;
    kind_t           status_kind;
  } cmd_t;

  function automatic logic [6:0] classify(input logic [7:0] ch);
    logic [6:0] code;
    case (ch) inside
      [8'h41:8'h5A]: code = 7'(ch - 8'h41);
      [8'h61:8'h7A]: code = 7'(ch - 8'h61 + 8'd26);
      [8'h30:8'h39]: code = 7'(ch - 8'h30 + 8'd52);
      8'h2B:         code = SYM_PLUS;
      8'h2F:         code = SYM_SLASH;
      8'h0A:         code = SYM_SKIP;
      8'h3D:         code = SYM_PAD;
      default:       code = SYM_BAD;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/base64_stream_decoder.sv =====
// Top level of the Base64 stream decoder: configuration port, front end,
// command queue and back end. Depends on b64sd_pkg and the b64sd_* modules.
`timescale 1ns / 1ps

// The decoder takes one Base64 character per input transaction and gives one
// result per output transaction: decoded bytes (kind 0) and, closing every
// message, exactly one status with last set (1 done, 2 invalid character,
// 3 output overflow). A character is taken in every cycle while the command
// queue between the front and back ends has room; the back end sends one
// result per cycle when not stalled, and a character that completes a group
// of four gives three results, so an ordinary stream runs at one character
// per cycle. The queue holds four commands, each of up to four results, and
// a command keeps its slot until its last result has gone into the output
// register. Results pass a queue slot and the output register; stalls delay
// them. Line feeds are skipped, '=' ends decoding until the end item, and
// after an error the rest of the message is dropped with no further results.
// output_limit (byte address 0, reset 65535) caps the number of bytes per
// message; a group that would pass it gives an overflow status in place of
// its bytes. Write the limit only while the block is idle.

module base64_stream_decoder #(
  parameter int COUNT_WIDTH = b64sd_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // character input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          symbol,
  input  logic                                end_of_message,
  // result output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          data_byte,
  output logic [1:0]                          kind,
  output logic                                last,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [b64sd_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [b64sd_pkg::LIMIT_WIDTH-1:0] output_limit;
  logic                              fire, push, pop, head_valid;
  b64sd_pkg::cmd_t                   push_cmd, head_cmd;
  b64sd_pkg::kind_t                  out_kind;

  // The register port never inserts wait states.
  assign pready = 1'b1;
  assign prdata = (paddr == b64sd_pkg::ADDR_OUTPUT_LIMIT) ?
                  {16'd0, output_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= b64sd_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == b64sd_pkg::ADDR_OUTPUT_LIMIT) begin
      output_limit <= pwdata[b64sd_pkg::LIMIT_WIDTH-1:0];
    end
  end

  // A character is taken whenever the queue has room, also one that produces
  // no command; such characters pass straight through with no push.
  assign fire = in_valid && in_ready;

  b64sd_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .symbol         (symbol),
    .end_of_message (end_of_message),
    .output_limit   (output_limit),
    .push           (push),
    .cmd            (push_cmd)
  );

  b64sd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .not_full   (in_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  b64sd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .out_kind   (out_kind),
    .last       (last)
  );

  assign kind = out_kind;

endmodule

// ===== rtl/b64sd_front.sv =====
// Front end: accepts characters, keeps the per-message decode state and
// turns each character into at most one command. Depends on b64sd_pkg.
`timescale 1ns / 1ps

module b64sd_front #(
  parameter int COUNT_WIDTH = b64sd_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic [7:0]                      symbol,
  input  logic                            end_of_message,
  input  logic [b64sd_pkg::LIMIT_WIDTH-1:0] output_limit,
  output logic                            push,
  output b64sd_pkg::cmd_t                 cmd
);

  localparam int SumW = ((COUNT_WIDTH + 1) > b64sd_pkg::LIMIT_WIDTH) ?
                        (COUNT_WIDTH + 1) : b64sd_pkg::LIMIT_WIDTH;

  logic [17:0]            acc, acc_next;
  logic [1:0]             cnt, cnt_next;
  logic [COUNT_WIDTH-1:0] emitted, emitted_next;
  logic                   pad, pad_next;
  logic                   drain, drain_next;

  logic [6:0]      code;
  logic [SumW-1:0] sum1, sum2, sum3, limit_ext;
  logic            room1, room2, room3;
  logic            group_ovf, clear;

  assign code      = b64sd_pkg::classify(symbol);
  assign limit_ext = SumW'(output_limit);
  assign sum1      = SumW'(emitted) + SumW'(1);
  assign sum2      = SumW'(emitted) + SumW'(2);
  assign sum3      = SumW'(emitted) + SumW'(3);
  // A sum must not exceed the limit and must fit in the counter.
  assign room1 = (sum1 <= limit_ext) && (sum1[SumW-1:COUNT_WIDTH] == '0);
  assign room2 = (sum2 <= limit_ext) && (sum2[SumW-1:COUNT_WIDTH] == '0);
  assign room3 = (sum3 <= limit_ext) && (sum3[SumW-1:COUNT_WIDTH] == '0);

  always_comb begin
    cmd             = '0;
    cmd.status_kind = b64sd_pkg::KIND_DONE;
    acc_next        = acc;
    cnt_next        = cnt;
    emitted_next    = emitted;
    pad_next        = pad;
    drain_next      = drain;
    group_ovf       = 1'b0;
    clear           = 1'b0;
    if (drain) begin
      clear = end_of_message;
    end else if (!pad && code == b64sd_pkg::SYM_BAD) begin
      cmd.has_status  = 1'b1;
      cmd.status_kind = b64sd_pkg::KIND_INVALID;
      clear           = end_of_message;
      drain_next      = !end_of_message;
    end else begin
      if (!pad && code == b64sd_pkg::SYM_PAD) begin
        pad_next = 1'b1;
      end else if (!pad && !code[6]) begin
        if (cnt == 2'd3) begin
          if (!room3) begin
            group_ovf       = 1'b1;
            cmd.has_status  = 1'b1;
            cmd.status_kind = b64sd_pkg::KIND_OVERFLOW;
            clear           = end_of_message;
            drain_next      = !end_of_message;
          end else begin
            cmd.bytes[0] = acc[17:10];
            cmd.bytes[1] = {acc[9:2]};
            cmd.bytes[2] = {acc[1:0], code[5:0]};
            cmd.ndata    = 2'd3;
            emitted_next = emitted + COUNT_WIDTH'(3);
            acc_next     = '0;
            cnt_next     = 2'd0;
          end
        end else begin
          acc_next = {acc[11:0], code[5:0]};
          cnt_next = cnt + 2'd1;
        end
      end
      // The end item flushes a partial group and closes the message.
      if (end_of_message && !group_ovf) begin
        clear          = 1'b1;
        cmd.has_status = 1'b1;
        case (cnt_next)
          2'd3: begin
            if (room2) begin
              cmd.bytes[0] = acc_next[17:10];
              cmd.bytes[1] = acc_next[9:2];
              cmd.ndata    = 2'd2;
            end else begin
              cmd.status_kind = b64sd_pkg::KIND_OVERFLOW;
            end
          end
          2'd2: begin
            if (room1) begin
              cmd.bytes[0] = acc_next[11:4];
              cmd.ndata    = 2'd1;
            end else begin
              cmd.status_kind = b64sd_pkg::KIND_OVERFLOW;
            end
          end
          default: begin
            cmd.status_kind = b64sd_pkg::KIND_DONE;
          end
        endcase
      end
    end
    if (clear) begin
      acc_next     = '0;
      cnt_next     = 2'd0;
      emitted_next = '0;
      pad_next     = 1'b0;
      drain_next   = 1'b0;
    end
  end

  assign push = fire && (cmd.has_status || cmd.ndata != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      cnt     <= 2'd0;
      emitted <= '0;
      pad     <= 1'b0;
      drain   <= 1'b0;
    end else if (fire) begin
      acc     <= acc_next;
      cnt     <= cnt_next;
      emitted <= emitted_next;
      pad     <= pad_next;
      drain   <= drain_next;
    end
  end

endmodule

// ===== rtl/b64sd_queue.sv =====
// Short command queue between the front and back ends of the decoder.
// Depends on b64sd_pkg for the command type and depth.
`timescale 1ns / 1ps

module b64sd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64sd_pkg::cmd_t push_cmd,
  output logic            not_full,
  input  logic            pop,
  output logic            head_valid,
  output b64sd_pkg::cmd_t head_cmd
);

  localparam int Depth = b64sd_pkg::QUEUE_DEPTH;
  localparam int AddrW = $clog2(Depth);

  b64sd_pkg::cmd_t    slots [Depth];
  logic [AddrW-1:0]   wr_ptr, rd_ptr;
  logic [AddrW:0]     count;

  assign not_full   = (count != (AddrW + 1)'(Depth));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + AddrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + AddrW'(1);
      end
      if (push && !pop) begin
        count <= count + (AddrW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (AddrW + 1)'(1);
      end
    end
  end

endmodule

// ===== rtl/b64sd_back.sv =====
// Back end: plays each queued command out as single result transactions
// through the output register. Depends on b64sd_pkg.
`timescale 1ns / 1ps

module b64sd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  b64sd_pkg::cmd_t  head_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       data_byte,
  output b64sd_pkg::kind_t out_kind,
  output logic             last
);

  logic [1:0] pos;
  logic [2:0] total;
  logic       load, is_data, last_item;
  logic [7:0] sel_byte;

  assign total     = {1'b0, head_cmd.ndata} + {2'b0, head_cmd.has_status};
  assign is_data   = (pos < head_cmd.ndata);
  assign last_item = ({1'b0, pos} + 3'd1 == total);
  assign load      = head_valid && (!out_valid || out_ready);
  assign pop       = load && last_item;

  always_comb begin
    case (pos)
      2'd0:    sel_byte = head_cmd.bytes[0];
      2'd1:    sel_byte = head_cmd.bytes[1];
      2'd2:    sel_byte = head_cmd.bytes[2];
      default: sel_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= last_item ? 2'd0 : pos + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_byte <= is_data ? sel_byte : 8'd0;
      out_kind  <= is_data ? b64sd_pkg::KIND_DATA : head_cmd.status_kind;
      last      <= !is_data;
    end
  end

endmodule

// ===== rtl/b64sd_checker.sv =====
// Port-level assertions for the Base64 stream decoder, bound to the top level.
// Depends on b64sd_pkg and base64_stream_decoder_assert.svh.
`timescale 1ns / 1ps
`include "base64_stream_decoder_assert.svh"

module b64sd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic [1:0] kind,
  input logic       last
);

  // A stalled result holds its value.
  `B64SD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(data_byte) && $stable(kind) && $stable(last))

  // Every status closes its message and no data byte does.
  `B64SD_ASSERT_NOW(a_last_is_status, out_valid, last == (kind != b64sd_pkg::KIND_DATA))

  // Status results carry a zero byte.
  `B64SD_ASSERT_NOW(a_status_zero, out_valid && kind != b64sd_pkg::KIND_DATA, data_byte == 8'd0)

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .data_byte (data_byte),
  .kind      (kind),
  .last      (last)
);
